// ----- rtl/x86_integer_alu_with_flags_top_macros.svh -----
// ----------------------------------------------------------------------------
// Integer ALU assertion macros
// Shared assertion forms for the checker of the integer ALU.
// ----------------------------------------------------------------------------
`ifndef X86_INTEGER_ALU_WITH_FLAGS_TOP_MACROS_SVH
`define X86_INTEGER_ALU_WITH_FLAGS_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define XALU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define XALU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/xalu_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer ALU package
// Opcodes, operand sizes, flag bit positions and the result record.
// ----------------------------------------------------------------------------
package xalu_pkg;

	localparam int unsigned DATA_W  = 64;
	localparam int unsigned FLAGS_W = 12;

	localparam int unsigned FLAG_CF = 0;
	localparam int unsigned FLAG_ZF = 6;
	localparam int unsigned FLAG_SF = 7;
	localparam int unsigned FLAG_TF = 8;
	localparam int unsigned FLAG_OF = 11;

	// Bits of the flags word that are always zero.
	localparam logic [FLAGS_W-1:0] FLAGS_ZERO_MASK = 12'h63E;

	typedef enum logic [3:0] {
		OPC_CMP  = 4'd0,
		OPC_ADD  = 4'd1,
		OPC_ADC  = 4'd2,
		OPC_SUB  = 4'd3,
		OPC_SBB  = 4'd4,
		OPC_INC  = 4'd5,
		OPC_DEC  = 4'd6,
		OPC_AND  = 4'd7,
		OPC_OR   = 4'd8,
		OPC_XOR  = 4'd9,
		OPC_NOT  = 4'd10,
		OPC_NEG  = 4'd11,
		OPC_XCHG = 4'd12
	} opcode_t;

	typedef enum logic [1:0] {
		SIZE_BYTE  = 2'd0,
		SIZE_WORD  = 2'd1,
		SIZE_DWORD = 2'd2,
		SIZE_QWORD = 2'd3
	} size_t;

	typedef struct packed {
		logic [DATA_W-1:0]  result_value;
		logic [DATA_W-1:0]  swap_value;
		logic               write_back;
		logic               flags_valid;
		logic [FLAGS_W-1:0] flags_word;
	} result_t;

endpackage

// ----- rtl/xalu_core.sv -----
// ----------------------------------------------------------------------------
// Integer ALU datapath
// One pass of add, subtract, logic or exchange at the selected operand size, with flags but for exchange.
// ----------------------------------------------------------------------------
module xalu_core import xalu_pkg::*; (
	input  logic [3:0]        req_type,
	input  logic [DATA_W-1:0] op_a,
	input  logic [DATA_W-1:0] op_b,
	input  logic [1:0]        size_code,
	input  logic              carry_in,
	input  logic              trap_in,
	output result_t           res
);

	function automatic logic top_bit(input logic [DATA_W-1:0] v, input logic [1:0] sz);
		logic b;
		unique case (size_t'(sz))
			SIZE_BYTE:  b = v[7];
			SIZE_WORD:  b = v[15];
			SIZE_DWORD: b = v[31];
			SIZE_QWORD: b = v[63];
			default:    b = v[63];
		endcase
		return b;
	endfunction

	logic [DATA_W-1:0] mask;
	logic [DATA_W-1:0] a_m;
	logic [DATA_W-1:0] b_m;
	logic [DATA_W-1:0] x;
	logic [DATA_W-1:0] y;
	logic              cin;
	logic              is_sub;
	logic [DATA_W-1:0] r_ar;
	logic [DATA_W-1:0] carry_vec;
	logic [DATA_W-1:0] ovf_vec;
	logic [DATA_W-1:0] r;
	logic              cf;
	logic              of_f;
	logic              wb;
	logic              known;
	logic              swap;

	always_comb begin
		unique case (size_t'(size_code))
			SIZE_BYTE:  mask = 64'h0000_0000_0000_00FF;
			SIZE_WORD:  mask = 64'h0000_0000_0000_FFFF;
			SIZE_DWORD: mask = 64'h0000_0000_FFFF_FFFF;
			SIZE_QWORD: mask = 64'hFFFF_FFFF_FFFF_FFFF;
			default:    mask = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
	end

	assign a_m = op_a & mask;
	assign b_m = op_b & mask;

	always_comb begin
		x      = a_m;
		y      = b_m;
		cin    = 1'b0;
		is_sub = 1'b0;
		unique case (opcode_t'(req_type))
			OPC_CMP, OPC_SUB: is_sub = 1'b1;
			OPC_ADC: cin = carry_in;
			OPC_SBB: begin
				cin    = carry_in;
				is_sub = 1'b1;
			end
			OPC_INC: y = 64'd1;
			OPC_DEC: begin
				y      = 64'd1;
				is_sub = 1'b1;
			end
			OPC_NEG: begin
				x      = '0;
				y      = a_m;
				is_sub = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (is_sub) begin
			r_ar      = (x - y - {{(DATA_W-1){1'b0}}, cin}) & mask;
			carry_vec = (~x & y) | ((~x | y) & r_ar);
			ovf_vec   = (x ^ y) & (x ^ r_ar);
		end else begin
			r_ar      = (x + y + {{(DATA_W-1){1'b0}}, cin}) & mask;
			carry_vec = (x & y) | ((x | y) & ~r_ar);
			ovf_vec   = ~(x ^ y) & (x ^ r_ar);
		end
	end

	always_comb begin
		r     = r_ar;
		cf    = top_bit(carry_vec, size_code);
		of_f  = top_bit(ovf_vec, size_code);
		wb    = 1'b1;
		known = 1'b1;
		swap  = 1'b0;
		unique case (opcode_t'(req_type))
			OPC_CMP: wb = 1'b0;
			OPC_ADD, OPC_ADC, OPC_SUB, OPC_SBB, OPC_NEG: ;
			OPC_INC, OPC_DEC: cf = carry_in;
			OPC_AND: begin
				r    = a_m & b_m;
				cf   = 1'b0;
				of_f = 1'b0;
			end
			OPC_OR: begin
				r    = a_m | b_m;
				cf   = 1'b0;
				of_f = 1'b0;
			end
			OPC_XOR: begin
				r    = a_m ^ b_m;
				cf   = 1'b0;
				of_f = 1'b0;
			end
			OPC_NOT: begin
				r    = ~a_m & mask;
				cf   = 1'b0;
				of_f = 1'b0;
			end
			OPC_XCHG: swap = 1'b1;
			default:  known = 1'b0;
		endcase
	end

	always_comb begin
		res = '0;
		if (swap) begin
			res.result_value = b_m;
			res.swap_value   = a_m;
			res.write_back   = 1'b1;
		end else if (known) begin
			res.result_value         = r;
			res.write_back           = wb;
			res.flags_valid          = 1'b1;
			res.flags_word[FLAG_CF]  = cf;
			res.flags_word[FLAG_ZF]  = (r == '0);
			res.flags_word[FLAG_SF]  = top_bit(r, size_code);
			res.flags_word[FLAG_TF]  = trap_in;
			res.flags_word[FLAG_OF]  = of_f;
		end
	end

endmodule

// ----- rtl/x86_integer_alu_with_flags_top.sv -----
// ----------------------------------------------------------------------------
// Integer ALU with flags
// Registered input, one datapath pass, registered result.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | req_type op_a op_b size_code carry_in trap_in
//  out     | out_valid/out_stall| result_value swap_value write_back
//          |                    | flags_valid flags_word
//
//  One transfer per cycle is accepted while in_stall is low; a result goes
//  through the input register and the result register to the output.
//  The single 64-bit add or subtract with its flag logic sets the clock period.
//  Reset clears both stage valid bits; payload registers are not reset.
//  A stalled result holds; the input register still fills behind it if empty.
// ----------------------------------------------------------------------------
module x86_integer_alu_with_flags_top import xalu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         req_type,
	input  logic [DATA_W-1:0]  op_a,
	input  logic [DATA_W-1:0]  op_b,
	input  logic [1:0]         size_code,
	input  logic               carry_in,
	input  logic               trap_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [DATA_W-1:0]  result_value,
	output logic [DATA_W-1:0]  swap_value,
	output logic               write_back,
	output logic               flags_valid,
	output logic [FLAGS_W-1:0] flags_word
);

	logic              valid_s1;
	logic              valid_s2;
	logic [3:0]        req_type_s1;
	logic [DATA_W-1:0] op_a_s1;
	logic [DATA_W-1:0] op_b_s1;
	logic [1:0]        size_code_s1;
	logic              carry_in_s1;
	logic              trap_in_s1;
	result_t           res_c;
	result_t           res_s2;
	logic              adv_s2;
	logic              adv_s1;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			req_type_s1  <= req_type;
			op_a_s1      <= op_a;
			op_b_s1      <= op_b;
			size_code_s1 <= size_code;
			carry_in_s1  <= carry_in;
			trap_in_s1   <= trap_in;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_c;
		end
	end

	xalu_core u_core (
		.req_type  (req_type_s1),
		.op_a      (op_a_s1),
		.op_b      (op_b_s1),
		.size_code (size_code_s1),
		.carry_in  (carry_in_s1),
		.trap_in   (trap_in_s1),
		.res       (res_c)
	);

	assign out_valid    = valid_s2;
	assign result_value = res_s2.result_value;
	assign swap_value   = res_s2.swap_value;
	assign write_back   = res_s2.write_back;
	assign flags_valid  = res_s2.flags_valid;
	assign flags_word   = res_s2.flags_word;

endmodule

// ----- rtl/xalu_checker.sv -----
// ----------------------------------------------------------------------------
// Integer ALU checker
// Port-level properties of the integer ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "x86_integer_alu_with_flags_top_macros.svh"

module xalu_checker import xalu_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [DATA_W-1:0]  result_value,
	input logic [DATA_W-1:0]  swap_value,
	input logic               write_back,
	input logic               flags_valid,
	input logic [FLAGS_W-1:0] flags_word
);

	`XALU_ASSERT_IMP(a_no_flags_zero, out_valid && !flags_valid, flags_word == '0,
		"flags word set without flag update")
	`XALU_ASSERT_IMP(a_no_wb_no_swap, out_valid && !write_back, swap_value == '0,
		"swap value set without write-back")
	`XALU_ASSERT_IMP(a_flag_bits, out_valid && flags_valid,
		(flags_word & FLAGS_ZERO_MASK) == '0, "reserved flag bit set")
	`XALU_ASSERT_NXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(result_value), "stalled result changed")
	`XALU_ASSERT_NXT(a_latency, (in_valid && !in_stall) ##1 !out_stall, out_valid,
		"accepted transfer did not reach the output")

endmodule

bind x86_integer_alu_with_flags_top xalu_checker u_xalu_checker (.*);
